// ===== design/rva_pkg.sv =====
// Shared types, constants and helpers for the axis-angle vector rotator.
// Used by every module of the design; depends on nothing else.
`default_nettype none

package rva_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int CS_W         = 34;
    localparam int Z_W          = 33;
    localparam int TRIG_W       = 32;
    localparam int VEC_W        = 32;
    localparam int AXIS_W       = 16;
    localparam int ANG_W        = 16;
    localparam int ENT_W        = 32;
    localparam int SC_LAT       = CORDIC_STEPS + 2;
    localparam int MAT_LAT      = 3;
    localparam int MAC_LAT      = 3;
    localparam int TOTAL_LAT    = SC_LAT + MAT_LAT + MAC_LAT;

    localparam logic signed [CS_W-1:0]   CORDIC_GAIN = CS_W'(34'sd652032874);
    localparam logic signed [CS_W-1:0]   ONE_Q30     = CS_W'(34'sd1073741824);
    localparam logic signed [AXIS_W-1:0] AXIS_ONE    = 16'sd16384;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
    };

    typedef struct packed {
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } cordic_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec3_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } axis3_t;

    typedef logic [8:0][ENT_W-1:0] mat_t;

    function automatic logic signed [AXIS_W-1:0] clamp_axis(
        input logic signed [AXIS_W-1:0] a
    );
        if (a > AXIS_ONE) begin
            return AXIS_ONE;
        end
        if (a < -AXIS_ONE) begin
            return -AXIS_ONE;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== design/rva_cordic_stage.sv =====
// One rotation-mode CORDIC step with its pipeline register.
// Depends on rva_pkg for the word type and the arctangent table.
`default_nettype none

module rva_cordic_stage
    import rva_pkg::*;
#(
    parameter int STEP = 0
)(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire cordic_t din,
    output cordic_t      dout
);

    cordic_t                data_reg;
    cordic_t                data_next;
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;

    assign dx  = din.y >>> STEP;
    assign dy  = din.x >>> STEP;
    assign ang = $signed({1'b0, ATAN_TAB[STEP]});

    always_comb
    begin
        data_next.flip = din.flip;
        if (!din.z[Z_W-1]) begin
            data_next.x = din.x - dx;
            data_next.y = din.y + dy;
            data_next.z = din.z - ang;
        end else begin
            data_next.x = din.x + dx;
            data_next.y = din.y - dy;
            data_next.z = din.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

// ===== design/rva_sincos.sv =====
// Sine and cosine of a binary angle: quadrant reduction, a chain of
// CORDIC steps and a final sign fix and clamp. Uses rva_pkg, rva_cordic_stage.
`default_nettype none

module rva_sincos
    import rva_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [ANG_W-1:0]         angle,
    output logic signed [TRIG_W-1:0]      sin_q30,
    output logic signed [TRIG_W-1:0]      cos_q30
);

    cordic_t                  init_reg;
    cordic_t                  init_next;
    cordic_t                  chain [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [CS_W-1:0]   xf;
    logic signed [CS_W-1:0]   yf;
    logic                     flip;
    logic signed [ANG_W-1:0]  q;

    assign flip = (angle > 16'd16384) && (angle < 16'd49152);
    assign q    = $signed(flip ? (angle ^ 16'h8000) : angle);

    always_comb
    begin
        init_next.x    = CORDIC_GAIN;
        init_next.y    = '0;
        init_next.z    = $signed({q[ANG_W-1], q, 16'h0000});
        init_next.flip = flip;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            init_reg <= init_next;
        end
    end

    assign chain[0] = init_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        rva_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk  (clk),
            .en   (en),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    always_comb
    begin
        xf = chain[CORDIC_STEPS].flip ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
        yf = chain[CORDIC_STEPS].flip ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
        if (xf > ONE_Q30) begin
            cos_next = TRIG_W'(ONE_Q30);
        end else if (xf < -ONE_Q30) begin
            cos_next = TRIG_W'(-ONE_Q30);
        end else begin
            cos_next = xf[TRIG_W-1:0];
        end
        if (yf > ONE_Q30) begin
            sin_next = TRIG_W'(ONE_Q30);
        end else if (yf < -ONE_Q30) begin
            sin_next = TRIG_W'(-ONE_Q30);
        end else begin
            sin_next = yf[TRIG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

`default_nettype wire

// ===== design/rva_mat.sv =====
// Builds the nine rotation matrix entries in Q.28 over three stages.
// Depends on rva_pkg.
`default_nettype none

module rva_mat
    import rva_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [TRIG_W-1:0] sin_q30,
    input  wire logic signed [TRIG_W-1:0] cos_q30,
    input  wire axis3_t                  axis,
    output mat_t                         mat
);

    logic signed [32:0]       t_reg;
    logic signed [31:0]       dg_reg;
    logic signed [31:0]       s_reg;
    logic signed [31:0]       kk_reg [6];
    axis3_t                   k_reg;
    logic signed [31:0]       dg2_reg;
    logic signed [31:0]       tk_reg [6];
    logic signed [31:0]       sk_reg [3];
    logic signed [64:0]       tprod [6];
    logic signed [47:0]       sprod [3];
    mat_t                     mat_reg;
    mat_t                     mat_next;
    logic signed [31:0]       txx, tyy, tzz, txy, txz, tyz, sx, sy, sz;

    always_ff @(posedge clk)
    begin
        if (en) begin
            t_reg     <= 33'sd1073741824 - 33'(cos_q30);
            dg_reg    <= cos_q30 >>> 2;
            s_reg     <= sin_q30;
            k_reg     <= axis;
            kk_reg[0] <= 32'(axis.x * axis.x);
            kk_reg[1] <= 32'(axis.y * axis.y);
            kk_reg[2] <= 32'(axis.z * axis.z);
            kk_reg[3] <= 32'(axis.x * axis.y);
            kk_reg[4] <= 32'(axis.x * axis.z);
            kk_reg[5] <= 32'(axis.y * axis.z);
        end
    end

    for (genvar i = 0; i < 6; i++) begin : g_tk
        assign tprod[i] = 65'(t_reg) * 65'(kk_reg[i]);
    end

    assign sprod[0] = 48'(s_reg) * 48'(k_reg.x);
    assign sprod[1] = 48'(s_reg) * 48'(k_reg.y);
    assign sprod[2] = 48'(s_reg) * 48'(k_reg.z);

    always_ff @(posedge clk)
    begin
        if (en) begin
            dg2_reg <= dg_reg;
            for (int i = 0; i < 6; i++) begin
                tk_reg[i] <= tprod[i][61:30];
            end
            for (int i = 0; i < 3; i++) begin
                sk_reg[i] <= sprod[i][47:16];
            end
        end
    end

    always_comb
    begin
        txx = tk_reg[0];
        tyy = tk_reg[1];
        tzz = tk_reg[2];
        txy = tk_reg[3];
        txz = tk_reg[4];
        tyz = tk_reg[5];
        sx  = sk_reg[0];
        sy  = sk_reg[1];
        sz  = sk_reg[2];
        mat_next[0] = txx + dg2_reg;
        mat_next[1] = txy - sz;
        mat_next[2] = txz + sy;
        mat_next[3] = txy + sz;
        mat_next[4] = tyy + dg2_reg;
        mat_next[5] = tyz - sx;
        mat_next[6] = txz - sy;
        mat_next[7] = tyz + sx;
        mat_next[8] = tzz + dg2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

// ===== design/rva_mac.sv =====
// Matrix times vector: products, row sums with rounding, then the shift
// and saturation to Q16.16. Depends on rva_pkg.
`default_nettype none

module rva_mac
    import rva_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire mat_t  mat,
    input  wire vec3_t vec,
    output vec3_t      res
);

    logic signed [63:0]     prod_reg [9];
    logic signed [65:0]     sum_reg  [3];
    logic signed [65:0]     sh       [3];
    logic signed [VEC_W-1:0] sat     [3];
    vec3_t                  res_reg;
    logic signed [VEC_W-1:0] v       [3];

    assign v[0] = vec.x;
    assign v[1] = vec.y;
    assign v[2] = vec.z;

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= $signed(mat[i]) * v[i % 3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r] <= 66'(prod_reg[3*r]) + 66'(prod_reg[3*r+1])
                            + 66'(prod_reg[3*r+2]) + 66'sd134217728;
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++) begin
            sh[r] = sum_reg[r] >>> 28;
            if (sh[r][65:31] == {35{sh[r][31]}}) begin
                sat[r] = sh[r][31:0];
            end else if (sh[r][65]) begin
                sat[r] = 32'sh80000000;
            end else begin
                sat[r] = 32'sh7FFFFFFF;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            res_reg.x <= sat[0];
            res_reg.y <= sat[1];
            res_reg.z <= sat[2];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/rotate_vector_around_axis_top.sv =====
// Top level of the axis-angle vector rotator: valid tracking, payload
// delay lines and the stall control. Uses rva_pkg, rva_sincos, rva_mat, rva_mac.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   vec_x..vec_z, axis_x..axis_z, turn_angle
//   output   out_valid / out_ready out_x, out_y, out_z
//
// One word enters per cycle while the output is not stalled; a result is
// presented at the end of 28 register stages: the 20 CORDIC steps, the
// sine/cosine entry and exit registers, and the matrix and product stages.
// Reset clears only the valid bits; no state is kept between words.
// When the output register holds an untaken word, the whole pipeline freezes.
`default_nettype none

module rotate_vector_around_axis_top
    import rva_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [VEC_W-1:0]  vec_x,
    input  wire logic signed [VEC_W-1:0]  vec_y,
    input  wire logic signed [VEC_W-1:0]  vec_z,
    input  wire logic signed [AXIS_W-1:0] axis_x,
    input  wire logic signed [AXIS_W-1:0] axis_y,
    input  wire logic signed [AXIS_W-1:0] axis_z,
    input  wire logic [ANG_W-1:0]         turn_angle,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [VEC_W-1:0]       out_x,
    output logic signed [VEC_W-1:0]       out_y,
    output logic signed [VEC_W-1:0]       out_z
);

    localparam int VEC_LAT = SC_LAT + MAT_LAT;

    logic [TOTAL_LAT-1:0]      valid_reg;
    logic [TOTAL_LAT-1:0]      valid_next;
    axis3_t                    axis_dly_reg [SC_LAT];
    vec3_t                     vec_dly_reg  [VEC_LAT];
    axis3_t                    axis_in;
    vec3_t                     vec_in;
    logic                      en;
    logic signed [TRIG_W-1:0]  sin_q30;
    logic signed [TRIG_W-1:0]  cos_q30;
    mat_t                      mat;
    vec3_t                     res;

    assign en       = !valid_reg[TOTAL_LAT-1] || out_ready;
    assign in_ready = en;

    assign axis_in.x = clamp_axis(axis_x);
    assign axis_in.y = clamp_axis(axis_y);
    assign axis_in.z = clamp_axis(axis_z);
    assign vec_in.x  = vec_x;
    assign vec_in.y  = vec_y;
    assign vec_in.z  = vec_z;

    assign valid_next = {valid_reg[TOTAL_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            axis_dly_reg[0] <= axis_in;
            for (int i = 1; i < SC_LAT; i++) begin
                axis_dly_reg[i] <= axis_dly_reg[i-1];
            end
            vec_dly_reg[0] <= vec_in;
            for (int i = 1; i < VEC_LAT; i++) begin
                vec_dly_reg[i] <= vec_dly_reg[i-1];
            end
        end
    end

    rva_sincos u_sincos (
        .clk     (clk),
        .en      (en),
        .angle   (turn_angle),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30)
    );

    rva_mat u_mat (
        .clk     (clk),
        .en      (en),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30),
        .axis    (axis_dly_reg[SC_LAT-1]),
        .mat     (mat)
    );

    rva_mac u_mac (
        .clk (clk),
        .en  (en),
        .mat (mat),
        .vec (vec_dly_reg[VEC_LAT-1]),
        .res (res)
    );

    assign out_valid = valid_reg[TOTAL_LAT-1];
    assign out_x     = res.x;
    assign out_y     = res.y;
    assign out_z     = res.z;

endmodule

`default_nettype wire
